// ----- sv/sdsr_pkg.sv -----
// ----------------------------------------------------------------------------
// sdsr_pkg
// shared types, phase codes, command bytes and frame helpers for the
// sd card spi-mode bring-up and streaming sequencer
// ----------------------------------------------------------------------------
package sdsr_pkg;

  // data block geometry
  localparam int BLOCK_BYTES = 512;
  localparam int BLK_W       = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;
  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_BYTES - 1);

  // apb register map
  localparam int APB_ADDR_W = 4;
  localparam logic [1:0] REG_START_ADDR = 2'd0;
  localparam logic [1:0] REG_POLL_LIMIT = 2'd1;
  localparam logic [1:0] REG_PREAMBLE   = 2'd2;

  // register reset values
  localparam logic [31:0] START_ADDR_RST = 32'd0;
  localparam logic [7:0]  POLL_LIMIT_RST = 8'd10;
  localparam logic [7:0]  PREAMBLE_RST   = 8'd20;

  // sequencer phases
  localparam logic [3:0] PH_PRE       = 4'd0;
  localparam logic [3:0] PH_FRAME     = 4'd1;
  localparam logic [3:0] PH_FRAME_END = 4'd5;
  localparam logic [3:0] PH_POLL      = 4'd6;
  localparam logic [3:0] PH_POLL_END  = 4'd10;
  localparam logic [3:0] PH_DUMMY     = 4'd11;
  localparam logic [3:0] PH_TOKEN     = 4'd12;
  localparam logic [3:0] PH_DATA      = 4'd13;
  localparam logic [3:0] PH_CRC       = 4'd14;
  localparam logic [3:0] PH_FAIL      = 4'd15;

  // command slots
  localparam logic [2:0] CMD_GO_IDLE    = 3'd0;
  localparam logic [2:0] CMD_IF_COND    = 3'd1;
  localparam logic [2:0] CMD_APP        = 3'd2;
  localparam logic [2:0] CMD_OP_COND    = 3'd3;
  localparam logic [2:0] CMD_READ_MULTI = 3'd4;

  // frame byte positions
  localparam logic [2:0] FB_FIRST   = 3'd0;
  localparam logic [2:0] FB_CRC     = 3'd5;
  localparam logic [2:0] FB_DUMMY_1 = 3'd1;
  localparam logic [2:0] FB_CRC_2   = 3'd2;

  // bus bytes
  localparam logic [7:0] IDLE_BYTE  = 8'hFF;
  localparam logic [7:0] DATA_TOKEN = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;

  localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
  localparam logic [31:0] OP_COND_ARG = 32'h4000_0000;

  // status codes
  localparam logic [1:0] ST_INIT   = 2'd0;
  localparam logic [1:0] ST_STREAM = 2'd1;
  localparam logic [1:0] ST_FAIL   = 2'd2;

  typedef struct packed {
    logic [31:0] start_address;
    logic [7:0]  poll_limit;
    logic [7:0]  preamble_bytes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       select_low;
    logic [7:0] sample;
    logic       sample_valid;
    logic [1:0] status;
  } result_t;

  function automatic logic [7:0] cmd_code(input logic [2:0] cmd);
    logic [7:0] b;
    case (cmd)
      CMD_GO_IDLE:    b = 8'h40;
      CMD_IF_COND:    b = 8'h48;
      CMD_APP:        b = 8'h77;
      CMD_OP_COND:    b = 8'h69;
      CMD_READ_MULTI: b = 8'h52;
      default:        b = IDLE_BYTE;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cmd_crc(input logic [2:0] cmd);
    logic [7:0] b;
    case (cmd)
      CMD_GO_IDLE: b = 8'h95;
      CMD_IF_COND: b = 8'h87;
      default:     b = IDLE_BYTE;
    endcase
    return b;
  endfunction

  // byte at position idx of the six-byte command frame
  function automatic logic [7:0] frame_byte(input logic [2:0]  cmd,
                                            input logic [2:0]  idx,
                                            input logic [31:0] start_addr);
    logic [31:0] arg;
    logic [7:0]  b;
    case (cmd)
      CMD_IF_COND:    arg = IF_COND_ARG;
      CMD_OP_COND:    arg = OP_COND_ARG;
      CMD_READ_MULTI: arg = start_addr;
      default:        arg = 32'd0;
    endcase
    case (idx)
      3'd0:    b = cmd_code(cmd);
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = cmd_crc(cmd);
    endcase
    return b;
  endfunction

endpackage

// ----- sv/sdsr_cfg.sv -----
// ----------------------------------------------------------------------------
// sdsr_cfg
// apb register file: start address, poll limit and preamble length
// ----------------------------------------------------------------------------
module sdsr_cfg
  import sdsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_address  <= START_ADDR_RST;
      cfg_r.poll_limit     <= POLL_LIMIT_RST;
      cfg_r.preamble_bytes <= PREAMBLE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_ADDR: cfg_r.start_address  <= pwdata;
        REG_POLL_LIMIT: cfg_r.poll_limit     <= pwdata[7:0];
        REG_PREAMBLE:   cfg_r.preamble_bytes <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_ADDR: prdata = cfg_r.start_address;
      REG_POLL_LIMIT: prdata = {24'd0, cfg_r.poll_limit};
      REG_PREAMBLE:   prdata = {24'd0, cfg_r.preamble_bytes};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/sdsr_seq.sv -----
// ----------------------------------------------------------------------------
// sdsr_seq
// byte-exchange sequencer: state registers and next-byte decision logic
// ----------------------------------------------------------------------------
module sdsr_seq
  import sdsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       mode,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    res
);

  logic [3:0]       phase_r, phase_nxt;
  logic [2:0]       fbi_r, fbi_nxt;
  logic [7:0]       pc_r, pc_nxt;
  logic [BLK_W-1:0] bbc_r, bbc_nxt;

  logic [3:0]       phase_cur;
  logic [2:0]       fbi_cur;
  logic [7:0]       pc_cur;
  logic [BLK_W-1:0] bbc_cur;
  logic [3:0]       frame_off;
  logic [3:0]       poll_off;
  logic [2:0]       cmd;
  logic [2:0]       pcmd;
  logic [2:0]       fbi_inc;
  logic [7:0]       limit;
  logic [7:0]       tx;
  logic [7:0]       smp;
  logic             smp_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRE;
      fbi_r   <= '0;
      pc_r    <= '0;
      bbc_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      fbi_r   <= fbi_nxt;
      pc_r    <= pc_nxt;
      bbc_r   <= bbc_nxt;
    end
  end

  always_comb begin
    // restart beat behaves like the first beat after reset
    phase_cur = mode ? phase_r : PH_PRE;
    fbi_cur   = mode ? fbi_r   : 3'd0;
    pc_cur    = mode ? pc_r    : 8'd0;
    bbc_cur   = mode ? bbc_r   : '0;

    frame_off = phase_cur - PH_FRAME;
    poll_off  = phase_cur - PH_POLL;
    cmd       = frame_off[2:0];
    pcmd      = poll_off[2:0];
    fbi_inc   = fbi_cur + 3'd1;
    limit     = (cfg.poll_limit == 8'd0) ? 8'd1 : cfg.poll_limit;

    phase_nxt = phase_cur;
    fbi_nxt   = fbi_cur;
    pc_nxt    = pc_cur;
    bbc_nxt   = bbc_cur;
    tx        = IDLE_BYTE;
    smp       = 8'd0;
    smp_vld   = 1'b0;

    unique case (phase_cur) inside
      PH_PRE: begin
        if (pc_cur < cfg.preamble_bytes) begin
          pc_nxt = pc_cur + 8'd1;
        end else begin
          phase_nxt = PH_FRAME + {1'b0, CMD_GO_IDLE};
          fbi_nxt   = FB_FIRST;
          tx        = cmd_code(CMD_GO_IDLE);
        end
      end
      [PH_FRAME:PH_FRAME_END]: begin
        if (fbi_cur < FB_CRC) begin
          fbi_nxt = fbi_inc;
          tx      = frame_byte(cmd, fbi_inc, cfg.start_address);
        end else begin
          phase_nxt = PH_POLL + {1'b0, cmd};
          pc_nxt    = 8'd1;
        end
      end
      [PH_POLL:PH_POLL_END]: begin
        if (rx_byte == IDLE_BYTE && pc_cur < limit) begin
          pc_nxt = pc_cur + 8'd1;
        end else begin
          case (pcmd)
            CMD_GO_IDLE: begin
              if (rx_byte == R1_IDLE) begin
                phase_nxt = PH_FRAME + {1'b0, CMD_IF_COND};
                fbi_nxt   = FB_FIRST;
                tx        = cmd_code(CMD_IF_COND);
              end else begin
                phase_nxt = PH_FAIL;
              end
            end
            CMD_IF_COND: begin
              phase_nxt = PH_DUMMY;
              fbi_nxt   = FB_DUMMY_1;
            end
            CMD_APP: begin
              phase_nxt = PH_FRAME + {1'b0, CMD_OP_COND};
              fbi_nxt   = FB_FIRST;
              tx        = cmd_code(CMD_OP_COND);
            end
            CMD_OP_COND: begin
              fbi_nxt = FB_FIRST;
              if (rx_byte == R1_READY) begin
                phase_nxt = PH_FRAME + {1'b0, CMD_READ_MULTI};
                tx        = cmd_code(CMD_READ_MULTI);
              end else begin
                phase_nxt = PH_FRAME + {1'b0, CMD_APP};
                tx        = cmd_code(CMD_APP);
              end
            end
            default: begin
              if (rx_byte == R1_READY) begin
                phase_nxt = PH_TOKEN;
              end else begin
                phase_nxt = PH_FRAME + {1'b0, CMD_READ_MULTI};
                fbi_nxt   = FB_FIRST;
                tx        = cmd_code(CMD_READ_MULTI);
              end
            end
          endcase
        end
      end
      PH_DUMMY: begin
        if (fbi_cur < FB_CRC) begin
          fbi_nxt = fbi_inc;
        end else begin
          phase_nxt = PH_FRAME + {1'b0, CMD_APP};
          fbi_nxt   = FB_FIRST;
          tx        = cmd_code(CMD_APP);
        end
      end
      PH_TOKEN: begin
        if (rx_byte == DATA_TOKEN) begin
          phase_nxt = PH_DATA;
          bbc_nxt   = '0;
        end
      end
      PH_DATA: begin
        if (bbc_cur[0]) begin
          smp     = rx_byte;
          smp_vld = 1'b1;
        end
        if (bbc_cur != BLK_LAST) begin
          bbc_nxt = bbc_cur + BLK_W'(1);
        end else begin
          phase_nxt = PH_CRC;
          fbi_nxt   = FB_DUMMY_1;
        end
      end
      PH_CRC: begin
        if (fbi_cur < FB_CRC_2) begin
          fbi_nxt = fbi_inc;
        end else begin
          phase_nxt = PH_TOKEN;
        end
      end
      default: begin
        phase_nxt = PH_FAIL;
      end
    endcase

    res.tx_byte      = tx;
    res.select_low   = (phase_nxt == PH_PRE) || (phase_nxt == PH_FAIL);
    res.sample       = smp;
    res.sample_valid = smp_vld;
    if (phase_nxt == PH_FAIL) begin
      res.status = ST_FAIL;
    end else if (phase_nxt == PH_TOKEN || phase_nxt == PH_DATA || phase_nxt == PH_CRC) begin
      res.status = ST_STREAM;
    end else begin
      res.status = ST_INIT;
    end
  end

endmodule

// ----- sv/sd_spi_init_and_stream_reader_core.sv -----
// ----------------------------------------------------------------------------
// sd_spi_init_and_stream_reader_core
// sd card spi-mode sequencer: brings the card up (cmd0, cmd8, cmd55/acmd41,
// cmd18) one byte exchange per beat, then streams data blocks and passes
// out every second data byte as an audio sample
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  in       | in_valid/in_ready, in_mode, in_rx_byte  | to block
//  out      | out_valid/out_ready, out_tx_byte,       | from block
//           | out_select_low, out_sample,             |
//           | out_sample_valid, out_status            |
//  cfg      | psel, penable, pwrite, paddr, pwdata,   | apb slave
//           | prdata, pready                          |
//
//  one beat in gives exactly one beat out, registered and valid in the cycle after it is taken
//  a new beat is taken every cycle while the result register is empty or
//  being drained; the sequencer state and result register load together
//  reset (rst_n low, synchronous) puts the sequencer at the preamble and
//  loads the register defaults; in_mode low restarts without touching regs
//  an out stall holds the result and blocks the input only while full
// ----------------------------------------------------------------------------
module sd_spi_init_and_stream_reader_core
  import sdsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  // input beat: byte returned by the card
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [7:0]            in_rx_byte,

  // result beat: next byte to send and stream data
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_tx_byte,
  output logic                  out_select_low,
  output logic [7:0]            out_sample,
  output logic                  out_sample_valid,
  output logic [1:0]            out_status,

  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t    cfg;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    in_fire;

  // result register frees up when empty or when the current beat leaves
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  sdsr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // next-byte decision from the current state and the incoming byte
  sdsr_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .mode    (in_mode),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_byte      = res_r.tx_byte;
  assign out_select_low   = res_r.select_low;
  assign out_sample       = res_r.sample;
  assign out_sample_valid = res_r.sample_valid;
  assign out_status       = res_r.status;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sd card spi-mode bring-up and streaming
// sequencer: a card-like stimulus source answers each command frame, a
// cycle-accurate predictor computes every result beat, and a monitor checks
// the results in order while both channels stall at random
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdsr_pkg::*;

  // bench limits
  localparam int LIMIT_CYCLES = 200000;
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 1100;

  // sd command indexes as they appear in the first frame byte
  localparam logic [5:0] SD_GO_IDLE       = 6'd0;
  localparam logic [5:0] SD_SEND_IF_COND  = 6'd8;
  localparam logic [5:0] SD_APP_CMD       = 6'd55;
  localparam logic [5:0] SD_SEND_OP_COND  = 6'd41;
  localparam logic [5:0] SD_READ_MULTIPLE = 6'd18;
  localparam logic [7:0] CRC_GO_IDLE      = 8'h95;
  localparam logic [7:0] CRC_IF_COND      = 8'h87;

  // byte positions inside a frame, the dummy reads and the crc trailer
  localparam logic [2:0] POS_START     = 3'd0;
  localparam logic [2:0] POS_FIRST_RD  = 3'd1;
  localparam logic [2:0] POS_FRAME_END = 3'd5;
  localparam logic [2:0] POS_CRC_END   = 3'd2;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  idx;
    logic [7:0]  polls;
    logic [15:0] blk;
  } seq_state_t;

  localparam seq_state_t SEQ_RESET = '{phase: PH_PRE, idx: POS_START, polls: 8'd0,
                                      blk: 16'd0};

  // one beat toward the block: restart flag and card byte
  typedef struct packed {
    logic       mode;
    logic [7:0] rx;
  } card_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_mode = 1'b1;
  logic [7:0]            in_rx_byte = 8'hFF;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_tx_byte;
  logic                  out_select_low;
  logic [7:0]            out_sample;
  logic                  out_sample_valid;
  logic [1:0]            out_status;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  sd_spi_init_and_stream_reader_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tx_byte      (out_tx_byte),
    .out_select_low   (out_select_low),
    .out_sample       (out_sample),
    .out_sample_valid (out_sample_valid),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // register copy, the sequencer as the block sees it, and the card's view
  // of the sequencer used only to pick plausible replies ahead of time
  cfg_t       regs_shadow = '{start_address: START_ADDR_RST, poll_limit: POLL_LIMIT_RST,
                              preamble_bytes: PREAMBLE_RST};
  seq_state_t seq_live  = SEQ_RESET;
  seq_state_t card_view = SEQ_RESET;

  card_beat_t card_beats[$];
  result_t    spi_results[$];

  int   cycles = 0;
  int   mismatches = 0;
  logic in_took = 1'b0;
  card_beat_t next_beat;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // six-byte command frame: start bits + index, argument msb first, crc
  function automatic logic [7:0] frame_byte_at(input logic [2:0] slot, input logic [2:0] pos,
                                               input logic [31:0] addr);
    logic [5:0]  code;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [47:0] frame;
    arg = 32'd0;
    crc = IDLE_BYTE;
    case (slot)
      CMD_GO_IDLE: begin
        code = SD_GO_IDLE;
        crc  = CRC_GO_IDLE;
      end
      CMD_IF_COND: begin
        code = SD_SEND_IF_COND;
        arg  = IF_COND_ARG;
        crc  = CRC_IF_COND;
      end
      CMD_APP: code = SD_APP_CMD;
      CMD_OP_COND: begin
        code = SD_SEND_OP_COND;
        arg  = OP_COND_ARG;
      end
      default: begin
        code = SD_READ_MULTIPLE;
        arg  = addr;
      end
    endcase
    frame = {2'b01, code, arg, crc};
    frame = frame >> (8 * (5 - int'(pos)));
    return frame[7:0];
  endfunction

  // one byte exchange: next state and the result beat it yields
  function automatic void sd_seq_step(input seq_state_t cur, input cfg_t regs,
                                      input logic mode, input logic [7:0] rx,
                                      output seq_state_t nxt, output result_t res);
    seq_state_t s;
    logic [7:0] lim;
    logic [2:0] slot;
    logic [2:0] next_cmd;
    logic       launch;
    s = mode ? cur : SEQ_RESET;
    lim = (regs.poll_limit == 8'd0) ? 8'd1 : regs.poll_limit;
    launch = 1'b0;
    next_cmd = CMD_GO_IDLE;
    res = '0;
    res.tx_byte = IDLE_BYTE;

    if (s.phase == PH_PRE) begin
      if (s.polls < regs.preamble_bytes) s.polls = s.polls + 8'd1;
      else launch = 1'b1;
    end else if (s.phase >= PH_FRAME && s.phase <= PH_FRAME_END) begin
      slot = 3'(s.phase - PH_FRAME);
      if (s.idx < POS_FRAME_END) begin
        s.idx = s.idx + 3'd1;
        res.tx_byte = frame_byte_at(slot, s.idx, regs.start_address);
      end else begin
        s.phase = PH_POLL + 4'(slot);
        s.polls = 8'd1;
      end
    end else if (s.phase >= PH_POLL && s.phase <= PH_POLL_END) begin
      slot = 3'(s.phase - PH_POLL);
      if (rx == IDLE_BYTE && s.polls < lim) begin
        s.polls = s.polls + 8'd1;
      end else begin
        launch = 1'b1;
        case (slot)
          CMD_GO_IDLE: begin
            if (rx == R1_IDLE) begin
              next_cmd = CMD_IF_COND;
            end else begin
              launch = 1'b0;
              s.phase = PH_FAIL;
            end
          end
          CMD_IF_COND: begin
            // any reply, then the r7 tail is clocked out as dummy reads
            launch = 1'b0;
            s.phase = PH_DUMMY;
            s.idx = POS_FIRST_RD;
          end
          CMD_APP: next_cmd = CMD_OP_COND;
          CMD_OP_COND: next_cmd = (rx == R1_READY) ? CMD_READ_MULTI : CMD_APP;
          default: begin
            if (rx == R1_READY) begin
              launch = 1'b0;
              s.phase = PH_TOKEN;
            end else begin
              next_cmd = CMD_READ_MULTI;
            end
          end
        endcase
      end
    end else if (s.phase == PH_DUMMY) begin
      if (s.idx < POS_FRAME_END) begin
        s.idx = s.idx + 3'd1;
      end else begin
        launch = 1'b1;
        next_cmd = CMD_APP;
      end
    end else if (s.phase == PH_TOKEN) begin
      if (rx == DATA_TOKEN) begin
        s.phase = PH_DATA;
        s.blk = 16'd0;
      end
    end else if (s.phase == PH_DATA) begin
      // odd positions carry the sample bytes
      if (s.blk[0]) begin
        res.sample = rx;
        res.sample_valid = 1'b1;
      end
      if (int'(s.blk) + 1 < BLOCK_BYTES) begin
        s.blk = s.blk + 16'd1;
      end else begin
        s.phase = PH_CRC;
        s.idx = POS_FIRST_RD;
      end
    end else if (s.phase == PH_CRC) begin
      if (s.idx < POS_CRC_END) s.idx = s.idx + 3'd1;
      else s.phase = PH_TOKEN;
    end else begin
      s.phase = PH_FAIL;
    end

    if (launch) begin
      s.phase = PH_FRAME + 4'(next_cmd);
      s.idx = POS_START;
      res.tx_byte = frame_byte_at(next_cmd, POS_START, regs.start_address);
    end

    res.select_low = (s.phase == PH_PRE || s.phase == PH_FAIL);
    if (s.phase == PH_FAIL) res.status = ST_FAIL;
    else if (s.phase == PH_TOKEN || s.phase == PH_DATA || s.phase == PH_CRC)
      res.status = ST_STREAM;
    else res.status = ST_INIT;
    nxt = s;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // a stall with a chance of 6 in 100 on each call, none inside the calm window
  function automatic logic roll_idle();
    if (cycles >= CALM_FROM && cycles < CALM_TO) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  // what a well-behaved card would most likely return in the current phase
  function automatic card_beat_t card_reply(input seq_state_t v);
    card_beat_t b;
    int r;
    int pick;
    logic [2:0] slot;
    r = $urandom_range(999);
    pick = $urandom_range(999);
    b.mode = 1'b1;
    b.rx = 8'($urandom);
    if (v.phase == PH_FAIL) begin
      // halted: restart after a few beats
      if (r < 250) b.mode = 1'b0;
    end else if (r < 1) begin
      b.mode = 1'b0;
    end else if (v.phase == PH_PRE || (v.phase >= PH_FRAME && v.phase <= PH_FRAME_END)) begin
      if (r < 900) b.rx = IDLE_BYTE;
    end else if (v.phase >= PH_POLL && v.phase <= PH_POLL_END) begin
      slot = 3'(v.phase - PH_POLL);
      if (r < 300) begin
        b.rx = IDLE_BYTE;
      end else begin
        case (slot)
          CMD_GO_IDLE: if (pick < 930) b.rx = R1_IDLE;
          CMD_IF_COND: ;
          CMD_APP:     if (pick < 800) b.rx = R1_IDLE;
          CMD_OP_COND: b.rx = (pick < 650) ? R1_READY : R1_IDLE;
          default:     if (pick < 800) b.rx = R1_READY;
        endcase
      end
    end else if (v.phase == PH_TOKEN) begin
      if (r < 250) b.rx = DATA_TOKEN;
      else if (r < 900) b.rx = IDLE_BYTE;
    end
    return b;
  endfunction

  // queue one beat and advance the card's view of the sequencer
  task automatic push_beat(input logic mode, input logic [7:0] rx);
    card_beat_t b;
    seq_state_t v;
    result_t    unused;
    b.mode = mode;
    b.rx = rx;
    sd_seq_step(card_view, regs_shadow, mode, rx, v, unused);
    card_view = v;
    card_beats.push_back(b);
  endtask

  // restart, then n-1 beats chosen by the card model
  task automatic push_session(input int n);
    card_beat_t b;
    push_beat(1'b0, 8'($urandom));
    repeat (n - 1) begin
      b = card_reply(card_view);
      push_beat(b.mode, b.rx);
    end
  endtask

  // apb write then read back
  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({reg_idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (reg_idx)
      REG_START_ADDR: begin
        regs_shadow.start_address = value;
        want = value;
      end
      REG_POLL_LIMIT: begin
        regs_shadow.poll_limit = value[7:0];
        want = {24'd0, value[7:0]};
      end
      default: begin
        regs_shadow.preamble_bytes = value[7:0];
        want = {24'd0, value[7:0]};
      end
    endcase
    if (prdata !== want) begin
      mismatches++;
      $error("register %0d read back: expected %08h, got %08h", reg_idx, want, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] addr, input logic [7:0] limit,
                          input logic [7:0] pre);
    apb_write(REG_START_ADDR, addr);
    apb_write(REG_POLL_LIMIT, {24'd0, limit});
    apb_write(REG_PREAMBLE, {24'd0, pre});
  endtask

  // wait until every beat is out and every result is back
  task automatic drain();
    while (card_beats.size() != 0 || in_valid || spi_results.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // sender: one beat at a time, payload changes only at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (card_beats.size() != 0 && !roll_idle()) begin
        next_beat = card_beats.pop_front();
        in_valid <= 1'b1;
        in_mode <= next_beat.mode;
        in_rx_byte <= next_beat.rx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= !roll_idle();
  end

  // --------------------------------------------------------------------------
  // monitor: predict on every accepted beat, check every result beat
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %02h, got %02h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t    predicted;
    result_t    want;
    seq_state_t advanced;
    cycles <= cycles + 1;
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      sd_seq_step(seq_live, regs_shadow, in_mode, in_rx_byte, advanced, predicted);
      seq_live = advanced;
      spi_results.push_back(predicted);
    end
    if (rst_n && out_valid && out_ready) begin
      if (spi_results.size() == 0) begin
        mismatches++;
        $error("result beat with nothing expected");
      end else begin
        want = spi_results.pop_front();
        check_field("tx_byte", want.tx_byte, out_tx_byte);
        check_field("select_low", 8'(want.select_low), 8'(out_select_low));
        check_field("sample", want.sample, out_sample);
        check_field("sample_valid", 8'(want.sample_valid), 8'(out_sample_valid));
        check_field("status", 8'(want.status), 8'(out_status));
      end
    end
    if (cycles >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no preamble, poll limit zero acts as one, all-ones read address
    set_regs(32'hFFFF_FFFF, 8'd0, 8'd0);

    // restart on the first beat ignores its byte; cmd0 goes out at once
    push_beat(1'b0, 8'h5A);
    repeat (6) push_beat(1'b1, 8'hFF);
    push_beat(1'b1, R1_IDLE);
    // cmd8 frame with the card driving zeros, then a bad reply that is ignored
    repeat (6) push_beat(1'b1, 8'h00);
    push_beat(1'b1, 8'h7F);
    repeat (5) push_beat(1'b1, 8'h80);
    // cmd55 frame, then a timed-out reply that is ignored as well
    repeat (6) push_beat(1'b1, 8'hFF);
    push_beat(1'b1, IDLE_BYTE);
    // restart, then cmd0 answered with zero: halt
    push_beat(1'b0, 8'hFF);
    repeat (6) push_beat(1'b1, 8'hFF);
    push_beat(1'b1, 8'h00);
    push_beat(1'b1, 8'hFF);
    push_beat(1'b1, 8'h00);
    drain();

    // default-like timing, long enough to stream a full block and more
    set_regs($urandom, POLL_LIMIT_RST, PREAMBLE_RST);
    push_session(800);
    drain();

    // tightest legal settings: one poll, a ten-byte preamble
    set_regs(32'h0000_0000, 8'd1, 8'd10);
    push_session(150);
    drain();

    // widest settings
    set_regs($urandom, 8'd255, 8'd255);
    push_session(150);
    drain();

    // random settings
    set_regs($urandom, 8'($urandom_range(1, 255)), 8'($urandom_range(10, 255)));
    push_session(150);
    drain();

    repeat (5) @(posedge clk);
    if (mismatches == 0 && spi_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/sdsr_pkg.sv
sv/sdsr_cfg.sv
sv/sdsr_seq.sv
sv/sd_spi_init_and_stream_reader_core.sv
tb/tb_top.sv
